[rtl/sprd_pkg.sv]
// ---------------------------------------------------------------------------
// sprd_pkg - shared types and constants for the sprite run decoder
// Opcodes, the unpacked input word, the parser result and the palette request.
// ---------------------------------------------------------------------------
`default_nettype none

package sprd_pkg;

  // input word kinds carried on in_tuser
  localparam logic [1:0] OP_PAL_WR = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // palette entry after reset: opaque black, alpha in the top byte
  localparam logic [31:0] BLACK_OPAQUE = 32'hFF00_0000;

  // one input word, unpacked
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  pal_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [7:0]  data_byte;
  } in_item_t;

  // what the parser decided for the word just accepted
  typedef struct packed {
    logic        emit;
    logic        pix;
    logic        fend;
    logic [15:0] x;
    logic [15:0] y;
  } parse_res_t;

  // palette write and read request, only asserted on an accepted word
  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [31:0] wr_color;
    logic        rd_en;
    logic [7:0]  rd_idx;
  } pal_req_t;

endpackage

`default_nettype wire

[rtl/sprd_parser.sv]
// ---------------------------------------------------------------------------
// sprd_parser - frame and row parser
// Walks the block count, skip offset, colour count and index bytes of each row
// and issues palette writes and reads for the accepted word.
// ---------------------------------------------------------------------------
`default_nettype none

module sprd_parser
  import sprd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire in_item_t   item,
  output parse_res_t      res,
  output pal_req_t        req
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BLOCKS = 3'd1;
  localparam logic [2:0] PH_OFFSET = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_INDEX  = 3'd4;

  localparam logic [8:0] ENTRY_LIM = 9'(PALETTE_ENTRIES);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] x_r, x_nxt;
  logic [7:0]  blocks_r, blocks_nxt;
  logic [7:0]  colors_r, colors_nxt;

  logic        end_block;
  logic        end_row;
  logic [16:0] x_sum;
  logic [15:0] row_inc;
  logic        idx_ok;

  assign x_sum   = {1'b0, x_r} + {9'd0, item.data_byte};
  assign row_inc = row_r + 16'd1;
  assign idx_ok  = {1'b0, item.data_byte} < ENTRY_LIM;

  // next state and per-word decisions
  always_comb begin
    phase_nxt  = phase_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    x_nxt      = x_r;
    blocks_nxt = blocks_r;
    colors_nxt = colors_r;
    end_block  = 1'b0;
    end_row    = 1'b0;
    res        = '0;
    req        = '0;
    req.wr_idx   = item.pal_index;
    req.wr_color = {item.alpha, item.blue, item.green, item.red};
    req.rd_idx   = item.data_byte;

    if (fire) begin
      unique case (item.opcode)
        OP_PAL_WR: begin
          req.wr_en = ({1'b0, item.pal_index} < ENTRY_LIM);
        end
        OP_FRAME: begin
          width_nxt  = item.frame_width;
          height_nxt = item.frame_height;
          row_nxt    = '0;
          x_nxt      = '0;
          blocks_nxt = '0;
          colors_nxt = '0;
          phase_nxt  = (item.frame_height == 16'd0) ? PH_IDLE : PH_BLOCKS;
        end
        OP_DATA: begin
          unique case (phase_r)
            PH_BLOCKS: begin
              blocks_nxt = item.data_byte;
              if (item.data_byte == 8'd0) begin
                end_row = 1'b1;
              end else begin
                phase_nxt = PH_OFFSET;
              end
            end
            PH_OFFSET: begin
              x_nxt     = x_sum[16] ? 16'hFFFF : x_sum[15:0];
              phase_nxt = PH_COUNT;
            end
            PH_COUNT: begin
              colors_nxt = item.data_byte;
              if (item.data_byte == 8'd0) begin
                end_block = 1'b1;
              end else begin
                phase_nxt = PH_INDEX;
              end
            end
            PH_INDEX: begin
              if (idx_ok && (x_r < width_r)) begin
                res.pix    = 1'b1;
                res.x      = x_r;
                res.y      = row_r;
                req.rd_en  = 1'b1;
                x_nxt      = x_r + 16'd1;
              end
              colors_nxt = colors_r - 8'd1;
              if (colors_r == 8'd1) begin
                end_block = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase

          // block end may chain into row end
          if (end_block) begin
            blocks_nxt = blocks_r - 8'd1;
            if (blocks_r == 8'd1) begin
              end_row = 1'b1;
            end else begin
              phase_nxt = PH_OFFSET;
            end
          end

          // row end may close the frame
          if (end_row) begin
            x_nxt   = '0;
            row_nxt = row_inc;
            if (row_inc >= height_r) begin
              phase_nxt = PH_IDLE;
              res.fend  = 1'b1;
            end else begin
              phase_nxt = PH_BLOCKS;
            end
          end
        end
        OP_NOP: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    res.emit = res.pix | res.fend;
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      width_r  <= '0;
      height_r <= '0;
      row_r    <= '0;
      x_r      <= '0;
      blocks_r <= '0;
      colors_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      row_r    <= row_nxt;
      x_r      <= x_nxt;
      blocks_r <= blocks_nxt;
      colors_r <= colors_nxt;
    end
  end

  // inside a block there is always at least one block left
  a_blocks_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFFSET || phase_r == PH_COUNT || phase_r == PH_INDEX)
      |-> blocks_r != 8'd0)
    else $error("block count is zero inside a block");

  // index phase always has a colour pending
  a_colors_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_INDEX) |-> colors_r != 8'd0)
    else $error("colour count is zero in index phase");

  // a pixel is only issued inside the frame width
  a_pix_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    res.pix |-> (res.x < width_r && req.rd_en))
    else $error("pixel outside frame width or without palette read");

endmodule

`default_nettype wire

[rtl/sprd_palette.sv]
// ---------------------------------------------------------------------------
// sprd_palette - palette memory
// One write and one registered read per cycle; per-entry valid bits make an
// unwritten entry read as opaque black straight after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sprd_palette
  import sprd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pal_req_t    req,
  output logic [31:0]      rd_color
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [31:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic [31:0]                rd_word_r;
  logic                       rd_hit_r;
  logic [AW-1:0]              wa;
  logic [AW-1:0]              ra;

  assign wa = req.wr_idx[AW-1:0];
  assign ra = req.rd_idx[AW-1:0];

  // memory array, write then registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_color;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[ra];
      rd_hit_r  <= vld_r[ra];
    end
  end

  // entry written marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[wa] <= 1'b1;
    end
  end

  assign rd_color = rd_hit_r ? rd_word_r : BLACK_OPAQUE;

endmodule

`default_nettype wire

[rtl/sprd_outq.sv]
// ---------------------------------------------------------------------------
// sprd_outq - result stage and output register
// Holds the word waiting on the palette read, applies the byte order and
// drives the registered result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sprd_outq
  import sprd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire parse_res_t  res,
  input  wire logic [31:0] rd_color,
  input  wire logic        color_model,
  output logic             s1_ready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  output logic             out_pix,
  output logic             out_fend
);

  logic        s1_vld_r;
  logic        s1_pix_r;
  logic        s1_fend_r;
  logic [15:0] s1_x_r;
  logic [15:0] s1_y_r;
  logic        out_vld_r;
  logic        out_pix_r;
  logic        out_fend_r;
  logic [63:0] out_data_r;
  logic        s1_move;
  logic        s1_load;
  logic [31:0] word;

  assign s1_move  = s1_vld_r && (!out_vld_r || out_tready);
  assign s1_ready = !s1_vld_r || s1_move;
  assign s1_load  = fire && res.emit;

  // byte order per colour model, zero when no pixel
  always_comb begin
    word = color_model ? {rd_color[31:24], rd_color[7:0], rd_color[15:8], rd_color[23:16]}
                       : rd_color;
    if (!s1_pix_r) begin
      word = '0;
    end
  end

  // stage waiting on palette read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= 1'b1;
    end else if (s1_move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix_r  <= res.pix;
      s1_fend_r <= res.fend;
      s1_x_r    <= res.x;
      s1_y_r    <= res.y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r  <= s1_pix_r;
      out_fend_r <= s1_fend_r;
      out_data_r <= {word, s1_y_r, s1_x_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_pix    = out_pix_r;
  assign out_fend   = out_fend_r;

  // every result carries a pixel or a frame end
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_pix_r || out_fend_r))
    else $error("empty result word");

  // a frame-end-only result carries zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_pix_r) |-> out_data_r == 64'd0)
    else $error("non-pixel result with payload");

  // a full pipe under stall takes no input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_tready) |-> !s1_ready)
    else $error("input accepted while both stages are stalled");

endmodule

`default_nettype wire

[rtl/palette_sprite_run_decoder_unit.sv]
// ---------------------------------------------------------------------------
// palette_sprite_run_decoder_unit - palettised run-coded sprite decoder
// Decodes run-coded sprite rows into palette-mapped pixel writes.
//
//   channel  dir  tdata                                      tuser / tlast
//   in_      in   pal_index red green blue alpha             tuser: opcode
//                 frame_width frame_height data_byte
//   out_     out  pixel_x pixel_y pixel_word                 tuser: pixel_valid
//                                                            tlast: frame_end
//   cfg_     in   color_model                                -
//
// One input word per cycle while in_tready is high. A result passes through the
// pending stage, which waits on the palette read port, and then the output
// register. Reset is synchronous; palette entries read as opaque black until
// written, through per-entry valid bits cleared in the reset cycle. When the
// output stalls, the pending stage and output register fill and in_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module palette_sprite_run_decoder_unit
  import sprd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pal_index[7:0] red[15:8] green[23:16] blue[31:24] alpha[39:32]
  // frame_width[55:40] frame_height[71:56] data_byte[79:72]
  input  wire logic [79:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pixel_x[15:0] pixel_y[31:16] pixel_word[63:32]
  output logic [63:0]      out_tdata,
  // pixel_valid[0]
  output logic [0:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data
);

  in_item_t   item;
  parse_res_t res;
  pal_req_t   req;
  logic       fire;
  logic       s1_ready;
  logic [31:0] rd_color;
  logic       color_model_r;
  logic       out_pix;
  logic       out_fend;

  // unpack input word
  assign item.opcode       = in_tuser;
  assign item.pal_index    = in_tdata[7:0];
  assign item.red          = in_tdata[15:8];
  assign item.green        = in_tdata[23:16];
  assign item.blue         = in_tdata[31:24];
  assign item.alpha        = in_tdata[39:32];
  assign item.frame_width  = in_tdata[55:40];
  assign item.frame_height = in_tdata[71:56];
  assign item.data_byte    = in_tdata[79:72];

  assign in_tready = s1_ready;
  assign fire      = in_tvalid && s1_ready;

  // colour model register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_model_r <= 1'b0;
    end else if (cfg_valid) begin
      color_model_r <= cfg_data[0];
    end
  end

  sprd_parser #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res),
    .req   (req)
  );

  sprd_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_color (rd_color)
  );

  sprd_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .res         (res),
    .rd_color    (rd_color),
    .color_model (color_model_r),
    .s1_ready    (s1_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_pix     (out_pix),
    .out_fend    (out_fend)
  );

  assign out_tuser = out_pix;
  assign out_tlast = out_fend;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top - stream-level test of the palettised run-coded sprite decoder
// Drives palette writes, frame starts and coded row bytes with random gaps and
// output back-pressure. A scoreboard keeps its own copy of the palette and the
// row parser, predicts each pixel write and frame end, and compares every
// result word field by field, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sprd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int PAL_ENTRIES  = 256;
  // two-stage pipeline, plus a little margin
  localparam int PIPE_DRAIN   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1750;
  // one long row that drives the column counter into saturation
  localparam int SAT_ITEMS    = 1030;
  localparam int PHASE_ITEMS  = (RANDOM_ITEMS - SAT_ITEMS) / 4;
  // slowest run: ~1800 words, every gap and stall at its longest, one hold-off
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_BLOCKS,
    PARSE_OFFSET,
    PARSE_COUNT,
    PARSE_INDEX
  } parse_phase_e;

  typedef struct packed {
    logic        pix;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] word;
    logic        fend;
  } pixel_result_t;

  // palette and row parser copy, with the queue of pixel writes and frame ends still owed
  class pixel_scoreboard;
    logic [31:0]   palette [PAL_ENTRIES];
    bit            color_model;
    logic [15:0]   width_q;
    logic [15:0]   height_q;
    logic [15:0]   row_q;
    logic [15:0]   x_q;
    parse_phase_e  phase;
    logic [7:0]    blocks_q;
    logic [7:0]    colors_q;
    pixel_result_t pending [$];
    int            errors;

    function new();
      foreach (palette[i]) palette[i] = BLACK_OPAQUE;
      color_model = 1'b0;
      width_q     = '0;
      height_q    = '0;
      row_q       = '0;
      x_q         = '0;
      phase       = PARSE_IDLE;
      blocks_q    = '0;
      colors_q    = '0;
      errors      = 0;
    endfunction

    function void set_model(bit m);
      color_model = m;
    endfunction

    // swap red and blue when the blue-first order is selected
    function logic [31:0] ordered(logic [31:0] c);
      return color_model ? {c[31:24], c[7:0], c[15:8], c[23:16]} : c;
    endfunction

    function bit end_row();
      x_q   = '0;
      row_q = row_q + 16'd1;
      if (row_q >= height_q) begin
        phase = PARSE_IDLE;
        return 1'b1;
      end
      phase = PARSE_BLOCKS;
      return 1'b0;
    endfunction

    function bit end_block();
      blocks_q = blocks_q - 8'd1;
      if (blocks_q == 8'd0) return end_row();
      phase = PARSE_OFFSET;
      return 1'b0;
    endfunction

    function void note_input(logic [1:0] op, logic [79:0] data);
      logic [7:0]    idx;
      logic [7:0]    b;
      logic [16:0]   nx;
      pixel_result_t res;
      idx = data[7:0];
      b   = data[79:72];
      res = '0;
      case (op)
        OP_PAL_WR: begin
          if (int'(idx) < PAL_ENTRIES) palette[idx] = data[39:8];
        end
        OP_FRAME: begin
          width_q  = data[55:40];
          height_q = data[71:56];
          row_q    = '0;
          x_q      = '0;
          blocks_q = '0;
          colors_q = '0;
          phase    = (height_q == 16'd0) ? PARSE_IDLE : PARSE_BLOCKS;
        end
        OP_DATA: begin
          case (phase)
            PARSE_BLOCKS: begin
              blocks_q = b;
              if (b == 8'd0) res.fend = end_row();
              else phase = PARSE_OFFSET;
            end
            PARSE_OFFSET: begin
              nx    = {1'b0, x_q} + {9'd0, b};
              x_q   = nx[16] ? 16'hFFFF : nx[15:0];
              phase = PARSE_COUNT;
            end
            PARSE_COUNT: begin
              colors_q = b;
              if (b == 8'd0) res.fend = end_block();
              else phase = PARSE_INDEX;
            end
            PARSE_INDEX: begin
              if (int'(b) < PAL_ENTRIES && x_q < width_q) begin
                res.pix  = 1'b1;
                res.x    = x_q;
                res.y    = row_q;
                res.word = ordered(palette[b]);
                x_q      = x_q + 16'd1;
              end
              colors_q = colors_q - 8'd1;
              if (colors_q == 8'd0) res.fend = end_block();
            end
            default: phase = PARSE_IDLE;
          endcase
        end
        default: ;
      endcase
      if (res.pix || res.fend) pending = {pending, res};
    endfunction

    task report(string what);
      $display("tb_top: mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [63:0] d, logic pv, logic fe);
      pixel_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word x=%0d y=%0d colour=%h pix=%0b end=%0b",
                         d[15:0], d[31:16], d[63:32], pv, fe));
        return;
      end
      want = pending.pop_front();
      if (pv !== want.pix)
        report($sformatf("pixel_valid %0b, want %0b", pv, want.pix));
      if (d[15:0] !== want.x)
        report($sformatf("pixel_x %0d, want %0d", d[15:0], want.x));
      if (d[31:16] !== want.y)
        report($sformatf("pixel_y %0d, want %0d", d[31:16], want.y));
      if (d[63:32] !== want.word)
        report($sformatf("pixel_word %h, want %h", d[63:32], want.word));
      if (fe !== want.fend)
        report($sformatf("frame_end %0b, want %0b", fe, want.fend));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [79:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_NOP;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [0:0]  cfg_data   = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_ready;

  pixel_scoreboard sb = new();
  int sent_items  = 0;
  int cycle_count = 0;
  int frame_cut   = -1;
  bit tx_burst    = 1'b0;
  bit hold_req    = 1'b0;

  palette_sprite_run_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0], out_tlast);
  end

  // receiver: random stalls, burst stretches and the occasional long hold-off
  initial begin : receiver
    int r;
    int stall;
    int hold_cnt;
    int mode_cnt;
    bit rx_burst;
    mode_cnt = 0;
    rx_burst = 1'b0;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end else begin
        if (mode_cnt == 0) begin
          rx_burst = ($urandom_range(0, 3) == 0);
          mode_cnt = 64;
        end
        mode_cnt--;
        r = $urandom_range(0, 99);
        if (rx_burst || r < 70) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          stall = (r < 96) ? $urandom_range(1, 3) : $urandom_range(15, 40);
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [79:0] rand_word();
    logic [95:0] w;
    w = {$urandom, $urandom, $urandom};
    return w[79:0];
  endfunction

  // offer one word and hold it until taken, then maybe leave a gap
  task automatic send_word(input logic [1:0] op, input logic [79:0] data);
    int r;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (sent_items % 100 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_data(input logic [7:0] b);
    logic [79:0] d;
    d = rand_word();
    d[79:72] = b;
    send_word(OP_DATA, d);
  endtask

  task automatic send_frame(input logic [15:0] w, input logic [15:0] h);
    logic [79:0] d;
    d = rand_word();
    d[55:40] = w;
    d[71:56] = h;
    send_word(OP_FRAME, d);
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [31:0] colour);
    logic [79:0] d;
    d = rand_word();
    d[7:0]  = idx;
    d[39:8] = colour;
    send_word(OP_PAL_WR, d);
  endtask

  // coded byte of a random frame: may be cut short, or have a stray word ahead of it
  task automatic frame_byte(input logic [7:0] b);
    if (frame_cut == 0) return;
    if (frame_cut > 0) frame_cut--;
    if ($urandom_range(0, 49) == 0) send_data(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 24) == 0) send_pal(8'($urandom_range(0, 255)), $urandom);
    send_data(b);
  endtask

  task automatic rand_frame();
    int r;
    int w;
    int h;
    int nb;
    int cnt;
    r = $urandom_range(0, 99);
    if (r < 70) w = $urandom_range(0, 24);
    else if (r < 90) w = $urandom_range(0, 65535);
    else w = $urandom_range(0, 1) ? 65535 : 0;
    h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
    frame_cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 12) : -1;
    send_frame(16'(w), 16'(h));
    for (int row = 0; row < h; row++) begin
      nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      frame_byte(8'(nb));
      for (int blk = 0; blk < nb; blk++) begin
        frame_byte(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6)));
        cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        frame_byte(8'(cnt));
        repeat (cnt) frame_byte(8'($urandom_range(0, 255)));
      end
    end
    frame_cut = -1;
  endtask

  // mostly well-formed frames, the rest loose words of any kind
  task automatic random_step();
    int n;
    if ($urandom_range(0, 99) < 85) rand_frame();
    else begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(2'($urandom_range(0, 3)), rand_word());
    end
  endtask

  // stop offering, let every owed result arrive and the pipeline empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_color_model(input bit m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_model(m);
  endtask

  initial begin : stimulus
    int target;
    int cnt;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data with no frame, unused opcode, zero-height frame
    send_data(8'h07);
    send_word(OP_NOP, rand_word());
    send_frame(16'd4, 16'd0);
    send_data(8'h01);
    // row 0 reads untouched entries, which must come out opaque black
    send_frame(16'd4, 16'd3);
    send_data(8'd1); send_data(8'd0); send_data(8'd2);
    send_data(8'd0); send_data(8'd255);
    // empty row
    send_data(8'd0);
    // empty block, then a block that runs past the width on the last row
    send_data(8'd2); send_data(8'd1); send_data(8'd0);
    send_data(8'd2); send_data(8'd3);
    send_data(8'd9); send_data(8'd9); send_data(8'd9);
    // palette extremes, a full-size frame and a palette write in mid-row
    send_pal(8'd0, 32'h0000_0000);
    send_pal(8'd255, 32'hFFFF_FFFF);
    send_pal(8'h5A, 32'h7856_3412);
    send_frame(16'hFFFF, 16'hFFFF);
    send_data(8'd1); send_data(8'd255); send_data(8'd3);
    send_data(8'h5A);
    send_pal(8'h5A, 32'h8899_AABB);
    send_data(8'h5A);
    // restart in mid-frame; single pixel that also ends the frame
    send_frame(16'd2, 16'd1);
    send_data(8'd1); send_data(8'd0); send_data(8'd1); send_data(8'd255);
    wait_idle();

    // blue-first byte order
    write_color_model(1'b1);
    send_frame(16'd1, 16'd1);
    send_data(8'd1); send_data(8'd0); send_data(8'd2);
    send_data(8'h5A); send_data(8'h00);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_color_model(p % 2 == 1);
      // output held off while words keep coming, so the input stalls
      if (p == 1) hold_req = 1'b1;
      if (p == 2) begin
        // skip offsets and pixels push the column past 65535, where it sticks
        send_frame(16'hFFFF, 16'd1);
        send_data(8'd255);
        for (int blk = 0; blk < 255; blk++) begin
          send_data(8'd255);
          cnt = (blk < 2) ? 255 : (blk == 2) ? 1 : (blk == 254) ? 2 : 0;
          send_data(8'(cnt));
          repeat (cnt) send_data(8'($urandom_range(0, 255)));
        end
      end
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) random_step();
      wait_idle();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/sprd_pkg.sv
rtl/sprd_parser.sv
rtl/sprd_palette.sv
rtl/sprd_outq.sv
rtl/palette_sprite_run_decoder_unit.sv
dv/tb_top.sv
